// File: rtl/core/fwi_pkg.sv
package fwi_pkg;

  // field and datapath widths
  localparam int COEF_W  = 16;
  localparam int WORK_W  = 24;
  localparam int SAMP_W  = 18;
  localparam int ACC_W   = 28;
  localparam int EXP_W   = 26;
  localparam int KONST_W = 14;
  localparam int PROD_W  = EXP_W + KONST_W + 1;
  localparam int FRAC_W  = 12;
  localparam int RND_W   = PROD_W - FRAC_W;
  localparam int MSUM_W  = 32;

  // Q.12 multiplier constants
  localparam logic [KONST_W-1:0] K_C4   = 14'd5793;
  localparam logic [KONST_W-1:0] K_C6   = 14'd3135;
  localparam logic [KONST_W-1:0] K_C4C6 = 14'd4433;
  localparam logic [KONST_W-1:0] K_Q1   = 14'd4434;
  localparam logic [KONST_W-1:0] K_R1   = 14'd10703;
  localparam logic [KONST_W-1:0] K_Q2   = 14'd6270;
  localparam logic [KONST_W-1:0] K_R2   = 14'd15136;

  localparam logic signed [PROD_W-1:0] ROUND_HALF  = PROD_W'(2048);
  localparam logic signed [MSUM_W-1:0] LEVEL_SHIFT = MSUM_W'(2048);
  localparam logic signed [MSUM_W-1:0] WORK_MAX = MSUM_W'((2 ** (WORK_W - 1)) - 1);
  localparam logic signed [MSUM_W-1:0] WORK_MIN = -MSUM_W'(2 ** (WORK_W - 1));
  localparam logic signed [MSUM_W-1:0] SAMP_MAX = MSUM_W'((2 ** (SAMP_W - 1)) - 1);
  localparam logic signed [MSUM_W-1:0] SAMP_MIN = -MSUM_W'(2 ** (SAMP_W - 1));

  // sign codes of a matrix or microcode term
  localparam logic [1:0] SG_ZERO = 2'b00;
  localparam logic [1:0] SG_POS  = 2'b01;
  localparam logic [1:0] SG_NEG  = 2'b10;

  // add-stage matrix select
  localparam logic [1:0] MAT_B1 = 2'd0;
  localparam logic [1:0] MAT_A1 = 2'd1;
  localparam logic [1:0] MAT_A2 = 2'd2;
  localparam logic [1:0] MAT_A3 = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_B1   = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_A1   = 6'b001000,
    ST_A2   = 6'b010000,
    ST_A3   = 6'b100000
  } stage_e;

  // one matrix row: four slots of {sign, column}, slot 0 in the low bits
  typedef logic [19:0] row_nz_t;
  localparam logic [4:0] NZ_NONE = 5'd0;

  function automatic logic [4:0] pz(input logic [2:0] i);
    return {SG_POS, i};
  endfunction

  function automatic logic [4:0] ng(input logic [2:0] i);
    return {SG_NEG, i};
  endfunction

  localparam row_nz_t ADD_NZ [4][8] = '{
    '{ {NZ_NONE, NZ_NONE, NZ_NONE, pz(3'd0)},
       {NZ_NONE, NZ_NONE, NZ_NONE, pz(3'd4)},
       {NZ_NONE, NZ_NONE, ng(3'd6), pz(3'd2)},
       {NZ_NONE, NZ_NONE, pz(3'd6), pz(3'd2)},
       {NZ_NONE, NZ_NONE, pz(3'd5), ng(3'd3)},
       {pz(3'd7), ng(3'd5), ng(3'd3), pz(3'd1)},
       {NZ_NONE, NZ_NONE, ng(3'd7), pz(3'd1)},
       {pz(3'd7), pz(3'd5), pz(3'd3), pz(3'd1)} },
    '{ {NZ_NONE, ng(3'd7), pz(3'd6), ng(3'd5)},
       {NZ_NONE, NZ_NONE, ng(3'd1), pz(3'd0)},
       {NZ_NONE, NZ_NONE, ng(3'd3), pz(3'd2)},
       {NZ_NONE, NZ_NONE, pz(3'd1), pz(3'd0)},
       {NZ_NONE, NZ_NONE, ng(3'd7), pz(3'd6)},
       {NZ_NONE, NZ_NONE, NZ_NONE, pz(3'd4)},
       {NZ_NONE, NZ_NONE, NZ_NONE, pz(3'd3)},
       {NZ_NONE, NZ_NONE, NZ_NONE, pz(3'd7)} },
    '{ {NZ_NONE, NZ_NONE, NZ_NONE, pz(3'd7)},
       {NZ_NONE, NZ_NONE, NZ_NONE, pz(3'd0)},
       {NZ_NONE, NZ_NONE, NZ_NONE, pz(3'd4)},
       {NZ_NONE, NZ_NONE, pz(3'd2), pz(3'd1)},
       {NZ_NONE, NZ_NONE, pz(3'd6), pz(3'd3)},
       {NZ_NONE, NZ_NONE, ng(3'd2), pz(3'd1)},
       {NZ_NONE, NZ_NONE, ng(3'd6), pz(3'd3)},
       {NZ_NONE, NZ_NONE, pz(3'd5), ng(3'd0)} },
    '{ {NZ_NONE, NZ_NONE, pz(3'd4), pz(3'd0)},
       {NZ_NONE, NZ_NONE, pz(3'd3), pz(3'd2)},
       {NZ_NONE, NZ_NONE, pz(3'd5), ng(3'd1)},
       {NZ_NONE, NZ_NONE, ng(3'd7), pz(3'd6)},
       {NZ_NONE, NZ_NONE, pz(3'd7), pz(3'd6)},
       {NZ_NONE, NZ_NONE, pz(3'd5), pz(3'd1)},
       {NZ_NONE, NZ_NONE, pz(3'd3), ng(3'd2)},
       {NZ_NONE, NZ_NONE, pz(3'd4), ng(3'd0)} }
  };

  function automatic logic [4:0] add_slot(input logic [1:0] mat, input logic [2:0] row,
                                          input logic [1:0] slot);
    row_nz_t w;
    w = ADD_NZ[mat][row];
    case (slot)
      2'd0:    return w[4:0];
      2'd1:    return w[9:5];
      2'd2:    return w[14:10];
      default: return w[19:15];
    endcase
  endfunction

  // multiply-stage microcode: o = +-rnd(e1*k1) +-rnd(e2*k2) + e3 (doubled if dbl)
  typedef struct packed {
    logic [3:0][5:0]     addr;
    logic [3:0][1:0]     e1;
    logic [KONST_W-1:0]  k1;
    logic                neg1;
    logic [3:0][1:0]     e2;
    logic [KONST_W-1:0]  k2;
    logic                neg2;
    logic [3:0][1:0]     e3;
    logic                dbl;
  } mc_t;

  function automatic mc_t mul_code(input logic [5:0] idx);
    mc_t m;
    logic [2:0] r;
    logic [2:0] c;
    logic rot;
    logic xout;
    logic [5:0] x;
    logic [5:0] y;
    logic [KONST_W-1:0] kk;
    logic [KONST_W-1:0] kq;
    logic [KONST_W-1:0] kr;
    m = '0;
    r = idx[5:3];
    c = idx[2:0];
    rot = 1'b0;
    xout = 1'b1;
    x = {r, 3'd4};
    y = {r, 3'd6};
    kk = K_C6;
    kq = K_Q1;
    kr = K_R1;
    m.addr[0] = idx;
    if (r == 3'd0 || r == 3'd1 || r == 3'd3 || r == 3'd7) begin
      case (c) inside
        3'd2, 3'd5: begin
          m.e1[0] = SG_POS;
          m.k1 = K_C4;
        end
        3'd4: rot = 1'b1;
        3'd6: begin
          rot = 1'b1;
          xout = 1'b0;
        end
        default: m.e3[0] = SG_POS;
      endcase
    end else if (r == 3'd2 || r == 3'd5) begin
      kk = K_C4C6;
      kq = K_Q2;
      kr = K_R2;
      case (c) inside
        3'd2, 3'd5: begin
          m.e3[0] = SG_POS;
          m.dbl = 1'b1;
        end
        3'd4: rot = 1'b1;
        3'd6: begin
          rot = 1'b1;
          xout = 1'b0;
        end
        default: begin
          m.e1[0] = SG_POS;
          m.k1 = K_C4;
        end
      endcase
    end else if (c == 3'd4 || c == 3'd6) begin
      // shared butterfly of the four middle entries
      m.addr = {6'd52, 6'd38, 6'd54, 6'd36};
      m.k1 = K_C4;
      m.dbl = 1'b1;
      if (idx == 6'd36 || idx == 6'd54) begin
        m.e1 = {SG_POS, SG_POS, SG_NEG, SG_POS};
        m.e3 = {SG_ZERO, SG_ZERO, SG_POS, SG_POS};
        m.neg1 = (idx == 6'd54);
      end else begin
        m.e1 = {SG_NEG, SG_NEG, SG_NEG, SG_POS};
        m.e3 = (idx == 6'd38) ? {SG_POS, SG_NEG, SG_ZERO, SG_ZERO}
                              : {SG_NEG, SG_POS, SG_ZERO, SG_ZERO};
      end
    end else begin
      // column rotation between rows four and six
      rot = 1'b1;
      x = {3'd4, c};
      y = {3'd6, c};
      xout = (r == 3'd4);
      if (c == 3'd2 || c == 3'd5) begin
        kk = K_C4C6;
        kq = K_Q2;
        kr = K_R2;
      end
    end
    if (rot) begin
      m.addr[0] = x;
      m.addr[1] = y;
      m.e2[0] = SG_POS;
      m.e2[1] = SG_POS;
      m.k2 = kk;
      m.neg2 = 1'b1;
      if (xout) begin
        m.e1[0] = SG_POS;
        m.k1 = kq;
        m.neg1 = 1'b1;
      end else begin
        m.e1[1] = SG_POS;
        m.k1 = kr;
      end
    end
    return m;
  endfunction

  function automatic logic signed [EXP_W-1:0] comb4(
      input logic [3:0][1:0] s,
      input logic signed [WORK_W-1:0] o0, input logic signed [WORK_W-1:0] o1,
      input logic signed [WORK_W-1:0] o2, input logic signed [WORK_W-1:0] o3);
    logic signed [EXP_W-1:0] acc;
    logic signed [EXP_W-1:0] v;
    logic signed [WORK_W-1:0] op [4];
    op[0] = o0;
    op[1] = o1;
    op[2] = o2;
    op[3] = o3;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      v = EXP_W'(op[i]);
      case (s[i])
        SG_POS:  acc = acc + v;
        SG_NEG:  acc = acc - v;
        default: ;
      endcase
    end
    return acc;
  endfunction

  function automatic logic signed [WORK_W-1:0] sat_work(input logic signed [MSUM_W-1:0] v);
    if (v > WORK_MAX) return WORK_W'(WORK_MAX);
    if (v < WORK_MIN) return WORK_W'(WORK_MIN);
    return WORK_W'(v);
  endfunction

  function automatic logic signed [SAMP_W-1:0] sat_samp(input logic signed [MSUM_W-1:0] v);
    if (v > SAMP_MAX) return SAMP_W'(SAMP_MAX);
    if (v < SAMP_MIN) return SAMP_W'(SAMP_MIN);
    return SAMP_W'(v);
  endfunction

endpackage

// File: rtl/core/feig_winograd_idct_8x8_unit.sv
// Channel   Ports                                   Direction  Transaction
// command   start, busy, coef_value_i               in         start & !busy
// result    strobe_o, sample_value_o, sample_last_o out        strobe_o, one cycle
//
// Coefficients are taken one per cycle while busy is low; the 64th starts the transform.
// Transform: five passes over the block, four add passes and one multiply pass,
// all through the single work memory.
// Samples leave only during the final pass.
// Reset clears the counters and sequencer; stores hold undefined data until written.
// Results cannot be stalled; each sample is valid for exactly one cycle.
module feig_winograd_idct_8x8_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [fwi_pkg::COEF_W-1:0] coef_value_i,
  output logic                              strobe_o,
  output logic signed [fwi_pkg::SAMP_W-1:0] sample_value_o,
  output logic                              sample_last_o
);
  import fwi_pkg::*;

  logic                     wr;
  logic                     go;
  logic [5:0]               coef_addr;
  logic signed [COEF_W-1:0] coef_data;

  assign wr = start && !busy;

  fwi_loader u_loader (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .coef_value_i (coef_value_i),
    .rd_addr_i    (coef_addr),
    .rd_data_o    (coef_data),
    .go_o         (go)
  );

  fwi_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .go_i           (go),
    .coef_addr_o    (coef_addr),
    .coef_data_i    (coef_data),
    .busy_o         (busy),
    .strobe_o       (strobe_o),
    .sample_value_o (sample_value_o),
    .sample_last_o  (sample_last_o)
  );

endmodule

// File: rtl/core/fwi_loader.sv
module fwi_loader (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_i,
  input  logic signed [fwi_pkg::COEF_W-1:0] coef_value_i,
  input  logic [5:0]                        rd_addr_i,
  output logic signed [fwi_pkg::COEF_W-1:0] rd_data_o,
  output logic                              go_o
);
  import fwi_pkg::*;

  logic [5:0]               cnt_q;
  logic signed [COEF_W-1:0] mem [64];
  logic signed [COEF_W-1:0] rd_q;

  // coefficient count in raster order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (wr_i) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end

  // coefficient store
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[cnt_q] <= coef_value_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;
  assign go_o = wr_i && (cnt_q == 6'd63);

endmodule

// File: rtl/core/fwi_engine.sv
module fwi_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              go_i,
  output logic [5:0]                        coef_addr_o,
  input  logic signed [fwi_pkg::COEF_W-1:0] coef_data_i,
  output logic                              busy_o,
  output logic                              strobe_o,
  output logic signed [fwi_pkg::SAMP_W-1:0] sample_value_o,
  output logic                              sample_last_o
);
  import fwi_pkg::*;

  stage_e                    stage_q, stage_d;
  logic [4:0]                cnt_q;
  logic [5:0]                idx_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [1:0]                tsgn_q;
  logic signed [WORK_W-1:0]  opr_q [4];
  logic signed [PROD_W-1:0]  p1_q, p2_q;
  logic signed [WORK_W-1:0]  mem [128];
  logic signed [WORK_W-1:0]  rd_q;
  logic                      strobe_q;
  logic signed [SAMP_W-1:0]  samp_q;
  logic                      last_q;

  logic                      is_add;
  logic [1:0]                mat;
  logic [4:0]                jn, kn;
  logic [5:0]                add_addr;
  logic [1:0]                add_sgn;
  mc_t                       mc;
  logic [5:0]                raddr;
  logic                      rbank, wbank;
  logic                      fin, wen;
  logic signed [WORK_W-1:0]  src;
  logic signed [ACC_W-1:0]   term;
  logic signed [EXP_W-1:0]   emul;
  logic [KONST_W-1:0]        kmul;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  t1, t2;
  logic signed [RND_W-1:0]   rnd1, rnd2;
  logic signed [MSUM_W-1:0]  e3x, mres, ares;
  logic signed [WORK_W-1:0]  wdata;

  // stage decode
  assign is_add = (stage_q == ST_B1) || (stage_q == ST_A1) ||
                  (stage_q == ST_A2) || (stage_q == ST_A3);
  always_comb begin
    unique case (stage_q)
      ST_A1:   mat = MAT_A1;
      ST_A2:   mat = MAT_A2;
      ST_A3:   mat = MAT_A3;
      default: mat = MAT_B1;
    endcase
  end

  // term address and sign of the add stages: slot j,k of output row, column
  assign jn = add_slot(mat, idx_q[5:3], cnt_q[3:2]);
  assign kn = add_slot(mat, idx_q[2:0], cnt_q[1:0]);
  assign add_addr = {jn[2:0], kn[2:0]};
  always_comb begin
    if (jn[4:3] == SG_ZERO || kn[4:3] == SG_ZERO || cnt_q[4]) begin
      add_sgn = SG_ZERO;
    end else if (jn[4:3] == kn[4:3]) begin
      add_sgn = SG_POS;
    end else begin
      add_sgn = SG_NEG;
    end
  end

  assign mc = mul_code(idx_q);
  assign raddr = is_add ? add_addr : mc.addr[cnt_q[1:0]];
  assign coef_addr_o = add_addr;
  assign rbank = (stage_q == ST_A1) || (stage_q == ST_A3);
  assign wbank = (stage_q == ST_MUL) || (stage_q == ST_A2);

  assign fin = (stage_q != ST_IDLE) && (cnt_q == (is_add ? 5'd17 : 5'd7));
  assign wen = fin && (stage_q != ST_A3);

  // accumulate path
  assign src = (stage_q == ST_B1) ? WORK_W'(coef_data_i) : rd_q;
  always_comb begin
    case (tsgn_q)
      SG_POS:  term = ACC_W'(src);
      SG_NEG:  term = -ACC_W'(src);
      default: term = '0;
    endcase
  end

  // shared constant multiplier of the multiply stage
  assign emul = (cnt_q == 5'd5) ? comb4(mc.e1, opr_q[0], opr_q[1], opr_q[2], opr_q[3])
                                : comb4(mc.e2, opr_q[0], opr_q[1], opr_q[2], opr_q[3]);
  assign kmul = (cnt_q == 5'd5) ? mc.k1 : mc.k2;
  assign prod = PROD_W'(emul) * PROD_W'($signed({1'b0, kmul}));

  // round to nearest, ties up, then combine
  assign t1 = p1_q + ROUND_HALF;
  assign t2 = p2_q + ROUND_HALF;
  assign rnd1 = t1[PROD_W-1:FRAC_W];
  assign rnd2 = t2[PROD_W-1:FRAC_W];
  always_comb begin
    e3x = MSUM_W'(comb4(mc.e3, opr_q[0], opr_q[1], opr_q[2], opr_q[3]));
    if (mc.dbl) begin
      e3x = e3x <<< 1;
    end
    mres = (mc.neg1 ? -MSUM_W'(rnd1) : MSUM_W'(rnd1)) +
           (mc.neg2 ? -MSUM_W'(rnd2) : MSUM_W'(rnd2)) + e3x;
  end

  assign ares = MSUM_W'(acc_q);
  assign wdata = sat_work(is_add ? ares : mres);

  // sequencer
  always_comb begin
    stage_d = stage_q;
    unique case (stage_q)
      ST_IDLE: if (go_i) stage_d = ST_B1;
      ST_B1:   if (fin && idx_q == 6'd63) stage_d = ST_MUL;
      ST_MUL:  if (fin && idx_q == 6'd63) stage_d = ST_A1;
      ST_A1:   if (fin && idx_q == 6'd63) stage_d = ST_A2;
      ST_A2:   if (fin && idx_q == 6'd63) stage_d = ST_A3;
      ST_A3:   if (fin && idx_q == 6'd63) stage_d = ST_IDLE;
      default: stage_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= ST_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      stage_q  <= stage_d;
      strobe_q <= fin && (stage_q == ST_A3);
      last_q   <= fin && (stage_q == ST_A3) && (idx_q == 6'd63);
      if (stage_q == ST_IDLE || fin) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 5'd1;
      end
      if (stage_q == ST_IDLE) begin
        idx_q <= '0;
      end else if (fin) begin
        idx_q <= idx_q + 6'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    tsgn_q <= add_sgn;
    acc_q  <= (cnt_q == 5'd0) ? '0 : acc_q + term;
    if (stage_q == ST_MUL && cnt_q >= 5'd1 && cnt_q <= 5'd4) begin
      opr_q[2'(cnt_q - 5'd1)] <= rd_q;
    end
    if (cnt_q == 5'd5) begin
      p1_q <= prod;
    end
    if (cnt_q == 5'd6) begin
      p2_q <= prod;
    end
    if (fin && stage_q == ST_A3) begin
      samp_q <= sat_samp(ares + LEVEL_SHIFT);
    end
  end

  // ping-pong work store, one bank read while the other is written
  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[{wbank, idx_q}] <= wdata;
    end
    rd_q <= mem[{rbank, raddr}];
  end

  assign busy_o = (stage_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign sample_value_o = samp_q;
  assign sample_last_o = last_q;

  a_strobe_from_a3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(stage_q == ST_A3))
    else $error("sample strobe outside final stage");
  a_last_with_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> strobe_q)
    else $error("last flag without strobe");
  a_mul_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q == ST_MUL) |-> (cnt_q <= 5'd7))
    else $error("multiply step counter overrun");
  a_start_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q == ST_B1 && $past(stage_q == ST_IDLE)) |-> $past(go_i))
    else $error("transform started without a full block");

endmodule
